[design/swlp_pkg.sv]
`timescale 1ns / 1ps
// Package of the stopwatch block: mode type, action and register codes, widths
// and reset values. No dependencies.
package swlp_pkg;

  typedef enum logic [1:0] {
    MODE_STARTUP  = 2'd0,
    MODE_STOPPED  = 2'd1,
    MODE_COUNTING = 2'd2,
    MODE_OFF      = 2'd3
  } mode_t;

  localparam int ActionW = 3;
  localparam int RegIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int MillisW = 10;
  localparam int SecondsW = 6;
  localparam int MinutesW = 7;
  localparam int TicksW = 16;

  typedef logic [ActionW-1:0] action_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam action_t ACT_TICK  = 3'd0;
  localparam action_t ACT_START = 3'd1;
  localparam action_t ACT_STOP  = 3'd2;
  localparam action_t ACT_RESET = 3'd3;
  localparam action_t ACT_READY = 3'd4;

  localparam reg_idx_t REG_MS_STEP    = 2'd0;
  localparam reg_idx_t REG_LONG_PRESS = 2'd1;
  localparam reg_idx_t REG_BLINK      = 2'd2;

  localparam logic [MillisW-1:0] MS_STEP_RST    = 10'd8;
  localparam logic [TicksW-1:0]  LONG_PRESS_RST = 16'd3000;
  localparam logic [TicksW-1:0]  BLINK_RST      = 16'd125;

  localparam logic [SecondsW-1:0] SECS_PER_MIN = 6'd60;
  localparam logic [MinutesW-1:0] MINUTES_MAX  = 7'd99;

  typedef struct packed {
    mode_t                 mode;
    logic [MinutesW-1:0]   minutes;
    logic [SecondsW-1:0]   seconds;
    logic [MillisW-1:0]    millis;
    logic                  message_shown;
    logic                  hold_measuring;
  } res_t;

endpackage

[design/swlp_intf.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the stopwatch block: input events, results
// and configuration writes. Depends on swlp_pkg.
interface swlp_in_if;
  logic               valid;
  logic               ready;
  swlp_pkg::action_t  action;
  logic               reset_button_held;

  modport source (output valid, output action, output reset_button_held, input ready);
  modport sink (input valid, input action, input reset_button_held, output ready);
endinterface

interface swlp_out_if;
  logic              valid;
  logic              ready;
  swlp_pkg::mode_t   mode;
  logic [3:0]        minute_tens;
  logic [3:0]        minute_ones;
  logic [2:0]        second_tens;
  logic [3:0]        second_ones;
  logic [3:0]        milli_hundreds;
  logic [3:0]        milli_tens;
  logic [3:0]        milli_ones;
  logic              off_message_shown;
  logic              hold_measuring;

  modport source (
    output valid, output mode, output minute_tens, output minute_ones,
    output second_tens, output second_ones, output milli_hundreds,
    output milli_tens, output milli_ones, output off_message_shown,
    output hold_measuring, input ready
  );
  modport sink (
    input valid, input mode, input minute_tens, input minute_ones,
    input second_tens, input second_ones, input milli_hundreds,
    input milli_tens, input milli_ones, input off_message_shown,
    input hold_measuring, output ready
  );
endinterface

interface swlp_cfg_if;
  logic                 valid;
  logic                 ready;
  swlp_pkg::reg_idx_t   index;
  swlp_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/stopwatch_with_long_press_off_top.sv]
`timescale 1ns / 1ps
// Top level of the stopwatch with long-press power-off.
// Depends on swlp_pkg and the channel interfaces in swlp_intf.sv.
//
// Usage:
// Each input beat on in_ch carries one event (tick, start, stop, reset press,
// startup done) and the reset button level. Every accepted beat yields exactly
// one result beat on out_ch holding the mode and the time as decimal digits.
// The result is registered: the result of a beat accepted at one edge is valid
// after that edge. One beat is taken every cycle unless the receiver stalls;
// the state and the result register update together at the accepting edge.
// The result register is the only buffer on the output side. While a result
// waits, a new beat is still taken in the same cycle that out_ch.ready is high;
// if the receiver stalls, in_ch.ready drops and the waiting result holds.
// Configuration writes on cfg_ch are always taken and apply to the next beat;
// writes to an index past the last register are dropped.
// After the synchronous reset the block is in startup mode with the time at
// zero and the registers at their default values; no result is pending.
module stopwatch_with_long_press_off_top (
  input  logic        clk,
  input  logic        rst_n,
  swlp_in_if.sink     in_ch,
  swlp_out_if.source  out_ch,
  swlp_cfg_if.sink    cfg_ch
);
  import swlp_pkg::*;

  logic [MillisW-1:0]  ms_step_r;
  logic [TicksW-1:0]   long_press_r;
  logic [TicksW-1:0]   blink_ms_r;

  mode_t               mode_r, mode_nxt;
  logic [MillisW-1:0]  millis_r, millis_nxt;
  logic [SecondsW-1:0] seconds_r, seconds_nxt;
  logic [MinutesW-1:0] minutes_r, minutes_nxt;
  logic [TicksW-1:0]   hold_ticks_r, hold_ticks_nxt;
  logic                hold_pending_r, hold_pending_nxt;
  logic [TicksW-1:0]   blink_ticks_r, blink_ticks_nxt;
  logic                message_on_r, message_on_nxt;

  res_t                res_r;
  logic                out_valid_r;
  logic                accept;

  logic [MillisW:0]    ms_sum;
  logic [MillisW-1:0]  ms_wrapped;
  logic [1:0]          carries;
  logic [SecondsW-1:0] sec_sum;
  logic [TicksW-1:0]   hold_inc;
  logic [TicksW-1:0]   blink_inc;

  logic [15:0]         hund_prod;
  logic [3:0]          hund_digit;
  logic [6:0]          milli_rem;

  function automatic logic [3:0] div10_f(input logic [6:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd103;
    return p[13:10];
  endfunction

  function automatic logic [3:0] mod10_f(input logic [6:0] v);
    logic [6:0] q;
    q = 7'(div10_f(v));
    return 4'(v - 7'(q * 7'd10));
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_step_r    <= MS_STEP_RST;
      long_press_r <= LONG_PRESS_RST;
      blink_ms_r   <= BLINK_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MS_STEP:    ms_step_r    <= cfg_ch.data[MillisW-1:0];
        REG_LONG_PRESS: long_press_r <= cfg_ch.data;
        REG_BLINK:      blink_ms_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ms_sum = {1'b0, millis_r} + {1'b0, ms_step_r};
    if (ms_sum >= 11'd2000) begin
      ms_wrapped = MillisW'(ms_sum - 11'd2000);
      carries    = 2'd2;
    end else if (ms_sum >= 11'd1000) begin
      ms_wrapped = MillisW'(ms_sum - 11'd1000);
      carries    = 2'd1;
    end else begin
      ms_wrapped = ms_sum[MillisW-1:0];
      carries    = 2'd0;
    end
    sec_sum   = seconds_r + SecondsW'(carries);
    hold_inc  = (hold_ticks_r == '1) ? hold_ticks_r : hold_ticks_r + 1'b1;
    blink_inc = (blink_ticks_r == '1) ? blink_ticks_r : blink_ticks_r + 1'b1;
  end

  always_comb begin
    mode_nxt         = mode_r;
    millis_nxt       = millis_r;
    seconds_nxt      = seconds_r;
    minutes_nxt      = minutes_r;
    hold_ticks_nxt   = hold_ticks_r;
    hold_pending_nxt = hold_pending_r;
    blink_ticks_nxt  = blink_ticks_r;
    message_on_nxt   = message_on_r;
    if (hold_pending_r) begin
      if (!in_ch.reset_button_held) begin
        hold_pending_nxt = 1'b0;
        hold_ticks_nxt   = '0;
        if (mode_r != MODE_OFF) begin
          mode_nxt = MODE_STOPPED;
        end
      end else if (in_ch.action == ACT_TICK) begin
        if (hold_inc >= long_press_r) begin
          hold_pending_nxt = 1'b0;
          hold_ticks_nxt   = '0;
          mode_nxt         = MODE_OFF;
          blink_ticks_nxt  = '0;
          message_on_nxt   = 1'b0;
        end else begin
          hold_ticks_nxt = hold_inc;
        end
      end
    end else if (mode_r == MODE_STARTUP) begin
      if (in_ch.action == ACT_READY) begin
        mode_nxt = MODE_STOPPED;
      end
    end else begin
      unique case (in_ch.action)
        ACT_TICK: begin
          if (mode_r == MODE_COUNTING) begin
            millis_nxt = ms_wrapped;
            if (sec_sum >= SECS_PER_MIN) begin
              seconds_nxt = sec_sum - SECS_PER_MIN;
              minutes_nxt = (minutes_r >= MINUTES_MAX) ? '0 : minutes_r + 1'b1;
            end else begin
              seconds_nxt = sec_sum;
            end
          end else if (mode_r == MODE_OFF) begin
            if (blink_inc >= blink_ms_r) begin
              blink_ticks_nxt = '0;
              message_on_nxt  = !message_on_r;
            end else begin
              blink_ticks_nxt = blink_inc;
            end
          end
        end
        ACT_START: mode_nxt = MODE_COUNTING;
        ACT_STOP: begin
          if (mode_r != MODE_OFF) begin
            mode_nxt = MODE_STOPPED;
          end
        end
        ACT_RESET: begin
          millis_nxt       = '0;
          seconds_nxt      = '0;
          minutes_nxt      = '0;
          hold_ticks_nxt   = '0;
          hold_pending_nxt = in_ch.reset_button_held;
          if (!in_ch.reset_button_held && mode_r != MODE_OFF) begin
            mode_nxt = MODE_STOPPED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_STARTUP;
      millis_r       <= '0;
      seconds_r      <= '0;
      minutes_r      <= '0;
      hold_ticks_r   <= '0;
      hold_pending_r <= 1'b0;
      blink_ticks_r  <= '0;
      message_on_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        mode_r         <= mode_nxt;
        millis_r       <= millis_nxt;
        seconds_r      <= seconds_nxt;
        minutes_r      <= minutes_nxt;
        hold_ticks_r   <= hold_ticks_nxt;
        hold_pending_r <= hold_pending_nxt;
        blink_ticks_r  <= blink_ticks_nxt;
        message_on_r   <= message_on_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r.mode           <= mode_nxt;
      res_r.minutes        <= minutes_nxt;
      res_r.seconds        <= seconds_nxt;
      res_r.millis         <= millis_nxt;
      res_r.message_shown  <= (mode_nxt == MODE_OFF) && message_on_nxt;
      res_r.hold_measuring <= hold_pending_nxt;
    end
  end

  always_comb begin
    hund_prod  = 16'(res_r.millis) * 16'd41;
    hund_digit = hund_prod[15:12];
    milli_rem  = 7'(res_r.millis - MillisW'(hund_digit) * 10'd100);

    out_ch.valid             = out_valid_r;
    out_ch.mode              = res_r.mode;
    out_ch.minute_tens       = div10_f(res_r.minutes);
    out_ch.minute_ones       = mod10_f(res_r.minutes);
    out_ch.second_tens       = 3'(div10_f(7'(res_r.seconds)));
    out_ch.second_ones       = mod10_f(7'(res_r.seconds));
    out_ch.milli_hundreds    = hund_digit;
    out_ch.milli_tens        = div10_f(milli_rem);
    out_ch.milli_ones        = mod10_f(milli_rem);
    out_ch.off_message_shown = res_r.message_shown;
    out_ch.hold_measuring    = res_r.hold_measuring;
  end

`ifndef SYNTHESIS
  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (millis_r < 10'd1000) && (seconds_r < SECS_PER_MIN) && (minutes_r <= MINUTES_MAX))
    else $error("Time count out of range.");

  a_hold_not_in_startup: assert property (@(posedge clk) disable iff (!rst_n)
    hold_pending_r |-> (mode_r != MODE_STARTUP))
    else $error("Hold timed during startup.");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("Accepted beat produced no result.");

  a_blink_idle_unless_off: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode_nxt != MODE_OFF && mode_r != MODE_OFF) |=> $stable(blink_ticks_r))
    else $error("Blink counter moved outside off mode.");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the stopwatch with long-press power-off: a shadow
// stopwatch class predicts every result beat, plain tasks drive the channels.
// Depends on swlp_pkg, the channel interfaces and stopwatch_with_long_press_off_top.
module testbench;
  import swlp_pkg::*;

  localparam int WatchdogLimit = 4000;

  typedef struct {
    mode_t      mode;
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
    logic [3:0] ms_hundreds;
    logic [3:0] ms_tens;
    logic [3:0] ms_ones;
    logic       message_shown;
    logic       hold_measuring;
  } display_t;

  class stopwatch_shadow;
    int unsigned ms_step;
    int unsigned long_press;
    int unsigned blink_period;
    mode_t       mode;
    int unsigned millis;
    int unsigned seconds;
    int unsigned minutes;
    int unsigned hold_ticks;
    int unsigned blink_ticks;
    bit          hold_pending;
    bit          message_on;
    display_t    pending_displays[$];
    int          mismatches;

    function new();
      ms_step = 32'(MS_STEP_RST);
      long_press = 32'(LONG_PRESS_RST);
      blink_period = 32'(BLINK_RST);
      mode = MODE_STARTUP;
      millis = 0;
      seconds = 0;
      minutes = 0;
      hold_ticks = 0;
      blink_ticks = 0;
      hold_pending = 0;
      message_on = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_MS_STEP: ms_step = 32'(data[MillisW-1:0]);
        REG_LONG_PRESS: long_press = 32'(data);
        REG_BLINK: blink_period = 32'(data);
        default: ;
      endcase
    endfunction

    function void enter_off();
      mode = MODE_OFF;
      blink_ticks = 0;
      message_on = 0;
    endfunction

    function void end_hold();
      hold_pending = 0;
      hold_ticks = 0;
      if (mode != MODE_OFF) mode = MODE_STOPPED;
    endfunction

    function void advance_time();
      int unsigned ms;
      ms = millis + ms_step;
      while (ms >= 1000) begin
        ms -= 1000;
        seconds++;
        if (seconds >= 60) begin
          seconds = 0;
          minutes++;
          if (minutes > 99) minutes = 0;
        end
      end
      millis = ms;
    endfunction

    function void advance_blink();
      if (blink_ticks < 32'hFFFF) blink_ticks++;
      if (blink_ticks >= blink_period) begin
        blink_ticks = 0;
        message_on = !message_on;
      end
    endfunction

    function void note_event(action_t act, logic held);
      display_t d;
      if (hold_pending) begin
        if (!held) begin
          end_hold();
        end else if (act == ACT_TICK) begin
          if (hold_ticks < 32'hFFFF) hold_ticks++;
          if (hold_ticks >= long_press) begin
            hold_pending = 0;
            hold_ticks = 0;
            enter_off();
          end
        end
      end else if (mode == MODE_STARTUP) begin
        if (act == ACT_READY) mode = MODE_STOPPED;
      end else begin
        case (act)
          ACT_TICK: begin
            if (mode == MODE_COUNTING) advance_time();
            else if (mode == MODE_OFF) advance_blink();
          end
          ACT_START: mode = MODE_COUNTING;
          ACT_STOP: begin
            if (mode != MODE_OFF) mode = MODE_STOPPED;
          end
          ACT_RESET: begin
            millis = 0;
            seconds = 0;
            minutes = 0;
            hold_ticks = 0;
            hold_pending = 1;
            if (!held) end_hold();
          end
          default: ;
        endcase
      end
      d.mode = mode;
      d.min_tens = 4'(minutes / 10);
      d.min_ones = 4'(minutes % 10);
      d.sec_tens = 3'(seconds / 10);
      d.sec_ones = 4'(seconds % 10);
      d.ms_hundreds = 4'(millis / 100);
      d.ms_tens = 4'((millis % 100) / 10);
      d.ms_ones = 4'(millis % 10);
      d.message_shown = (mode == MODE_OFF) ? message_on : 1'b0;
      d.hold_measuring = hold_pending;
      pending_displays.push_back(d);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_display(display_t got);
      display_t want;
      if (pending_displays.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, mode expected none, got %0d",
                 $time, got.mode);
        return;
      end
      want = pending_displays.pop_front();
      compare_field("mode", 4'(want.mode), 4'(got.mode));
      compare_field("minute_tens", want.min_tens, got.min_tens);
      compare_field("minute_ones", want.min_ones, got.min_ones);
      compare_field("second_tens", 4'(want.sec_tens), 4'(got.sec_tens));
      compare_field("second_ones", want.sec_ones, got.sec_ones);
      compare_field("milli_hundreds", want.ms_hundreds, got.ms_hundreds);
      compare_field("milli_tens", want.ms_tens, got.ms_tens);
      compare_field("milli_ones", want.ms_ones, got.ms_ones);
      compare_field("off_message_shown", 4'(want.message_shown), 4'(got.message_shown));
      compare_field("hold_measuring", 4'(want.hold_measuring), 4'(got.hold_measuring));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   stall_pct;
  int   quiet_cycles = 0;
  display_t seen;
  stopwatch_shadow shadow;

  swlp_in_if  in_ch ();
  swlp_out_if out_ch ();
  swlp_cfg_if cfg_ch ();

  stopwatch_with_long_press_off_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.mode = out_ch.mode;
        seen.min_tens = out_ch.minute_tens;
        seen.min_ones = out_ch.minute_ones;
        seen.sec_tens = out_ch.second_tens;
        seen.sec_ones = out_ch.second_ones;
        seen.ms_hundreds = out_ch.milli_hundreds;
        seen.ms_tens = out_ch.milli_tens;
        seen.ms_ones = out_ch.milli_ones;
        seen.message_shown = out_ch.off_message_shown;
        seen.hold_measuring = out_ch.hold_measuring;
        shadow.check_display(seen);
      end
      if (in_ch.valid && in_ch.ready) begin
        shadow.note_event(in_ch.action, in_ch.reset_button_held);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        shadow.write_reg(cfg_ch.index, cfg_ch.data);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic put_event(input action_t act, input logic held);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.reset_button_held <= held;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (shadow.pending_displays.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_settings();
    cfg_data_t step, hold_limit, blink;
    case ($urandom_range(4))
      0: step = 16'd0;
      1: step = 16'd1;
      2: step = 16'd999;
      3: step = 16'd1023;
      default: step = 16'($urandom_range(1023));
    endcase
    case ($urandom_range(4))
      0: hold_limit = 16'd0;
      1: hold_limit = 16'd1;
      2: hold_limit = 16'hFFFF;
      default: hold_limit = 16'($urandom_range(16, 2));
    endcase
    case ($urandom_range(4))
      0: blink = 16'd0;
      1: blink = 16'd1;
      2: blink = 16'hFFFF;
      default: blink = 16'($urandom_range(8, 2));
    endcase
    write_reg(REG_MS_STEP, step);
    write_reg(REG_LONG_PRESS, hold_limit);
    write_reg(REG_BLINK, blink);
  endtask

  task automatic run_random(input int count, input int send_idle, input int recv_stall);
    action_t act;
    logic    held;
    int      r;
    stall_pct = recv_stall;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 50) act = ACT_TICK;
      else if (r < 62) act = ACT_START;
      else if (r < 70) act = ACT_STOP;
      else if (r < 78) act = ACT_RESET;
      else if (r < 82) act = ACT_READY;
      else if (r < 86) act = action_t'($urandom_range(7, 5));
      else act = ACT_TICK;
      if (shadow.hold_pending) held = ($urandom_range(99) < 93);
      else if (act == ACT_RESET) held = ($urandom_range(99) < 80);
      else held = 1'($urandom_range(1));
      if ($urandom_range(149) == 0) drain();
      sender_gap(send_idle);
      put_event(act, held);
    end
    drain();
  endtask

  initial begin
    shadow = new();
    stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.reset_button_held = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MS_STEP;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put_event(ACT_TICK, 1'b0);
    put_event(ACT_RESET, 1'b1);
    put_event(action_t'(6), 1'b1);
    put_event(ACT_READY, 1'b0);
    put_event(ACT_START, 1'b0);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_STOP, 1'b0);
    put_event(ACT_RESET, 1'b0);
    put_event(ACT_START, 1'b0);
    put_event(ACT_RESET, 1'b1);
    put_event(ACT_TICK, 1'b1);
    put_event(ACT_STOP, 1'b1);
    put_event(ACT_TICK, 1'b0);
    drain();

    write_reg(REG_MS_STEP, 16'd999);
    write_reg(REG_LONG_PRESS, 16'd2);
    write_reg(REG_BLINK, 16'd0);
    put_event(ACT_START, 1'b0);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_RESET, 1'b1);
    put_event(ACT_TICK, 1'b1);
    put_event(ACT_TICK, 1'b1);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_TICK, 1'b1);
    put_event(ACT_STOP, 1'b0);
    put_event(ACT_RESET, 1'b1);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_START, 1'b0);
    put_event(ACT_TICK, 1'b0);
    drain();

    write_reg(REG_MS_STEP, 16'd1023);
    write_reg(REG_LONG_PRESS, 16'd0);
    write_reg(REG_BLINK, 16'hFFFF);
    write_reg(reg_idx_t'(3), 16'hFFFF);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_RESET, 1'b1);
    put_event(ACT_TICK, 1'b1);
    put_event(ACT_TICK, 1'b0);
    put_event(ACT_START, 1'b0);
    put_event(ACT_STOP, 1'b0);
    drain();

    // Run the seconds past two minutes so that the carry reaches the minutes.
    write_reg(REG_MS_STEP, 16'd999);
    put_event(ACT_START, 1'b0);
    repeat (130) put_event(ACT_TICK, 1'b0);
    drain();

    pick_settings();
    run_random(180, 0, 0);
    pick_settings();
    run_random(180, 0, 0);
    pick_settings();
    run_random(180, 84, 0);
    pick_settings();
    run_random(180, 84, 0);
    pick_settings();
    run_random(180, 0, 84);
    pick_settings();
    run_random(180, 0, 84);
    pick_settings();
    run_random(180, 10, 10);
    pick_settings();
    run_random(180, 10, 10);

    stall_pct = 0;
    drain();
    if (shadow.mismatches == 0 && shadow.pending_displays.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
